// ----- rtl/core/deqd_pkg.sv -----
// Types and codes shared by the deque-with-delete unit and its storage cells.
package deqd_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W   = 5;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_DELETE     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped_value;
      logic [1:0]                status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // Per-item commands broadcast to every cell; already qualified by accept and occupancy.
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_front;
      logic del;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/double_ended_queue_with_delete_unit.sv -----
// Top level of the bounded double-ended queue with delete-first-match.
//
// Each item (push back, pop back, push front, pop front, delete first match)
// is applied to all cells at once: all entries live in a row of cells that
// compare against the item value and shift towards either end in the same
// edge, so busy never rises and a new item may be started every cycle. The
// result appears on rsp with rsp_valid high for exactly one cycle, in the
// cycle after the item was accepted, and must be taken then. Popping an empty
// queue returns 0 with an empty status; a push on a full queue is dropped and
// flagged; a delete that finds no equal entry reports not found. Occupancy is
// the entry count after the item.
module double_ended_queue_with_delete_unit
   import deqd_pkg::*;
#(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   cell_ctrl_type         ctrl;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  found;
   logic [DATA_WIDTH-1:0] value;
   logic [DATA_WIDTH-1:0] front_data;
   logic [DATA_WIDTH-1:0] back_data;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_back [CAPACITY];
   logic                  cell_seen [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == COUNT_W'(CAPACITY);
   assign empty  = count_ff == '0;
   assign value  = DATA_WIDTH'(req.value);

   assign front_data = cell_data[0];
   assign back_data  = cell_back[0];
   assign found      = cell_seen[CAPACITY-1];

   always_comb begin
      ctrl            = '0;
      count_in        = count_ff;
      rsp_in          = '0;
      rsp_in.status   = ST_OK;
      case (req.operation)
         OP_PUSH_BACK: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.push_back = accept;
               count_in       = count_ff + COUNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.popped_value = VALUE_W'(back_data);
               count_in            = count_ff - COUNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.push_front = accept;
               count_in        = count_ff + COUNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               ctrl.pop_front      = accept;
               rsp_in.popped_value = VALUE_W'(front_data);
               count_in            = count_ff - COUNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!found) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               ctrl.del = accept;
               count_in = count_ff - COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      logic                  seen_in;
      logic [DATA_WIDTH-1:0] back_in;

      if (i == 0) begin : g_head
         assign left_data = value;
         assign seen_in   = 1'b0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign seen_in   = cell_seen[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = cell_data[i];
         assign back_in    = '0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
         assign back_in    = cell_back[i+1];
      end

      deqd_cell #(
         .INDEX      (i),
         .DATA_WIDTH (DATA_WIDTH),
         .COUNT_W    (COUNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .value      (value),
         .left_data  (left_data),
         .right_data (right_data),
         .seen_in    (seen_in),
         .back_in    (back_in),
         .data       (cell_data[i]),
         .seen_out   (cell_seen[i]),
         .back_out   (cell_back[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item gave no result");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_FULL) |-> count_ff == COUNT_W'(CAPACITY))
      else $error("dropped push but queue not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_EMPTY) |-> (empty && rsp.popped_value == '0))
      else $error("empty status with entries held");
`endif

endmodule

// ----- rtl/core/deqd_cell.sv -----
// One storage cell of the deque: holds a single entry and shifts with its neighbours.
module deqd_cell
   import deqd_pkg::*;
#(
   parameter int unsigned INDEX      = 0,
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned COUNT_W    = 5
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [COUNT_W-1:0]    count,
   input  logic [DATA_WIDTH-1:0] value,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  seen_in,
   input  logic [DATA_WIDTH-1:0] back_in,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  seen_out,
   output logic [DATA_WIDTH-1:0] back_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  occupied;
   logic                  hit;

   assign occupied = count > COUNT_W'(INDEX);
   assign hit      = occupied && (data_ff == value);
   assign seen_out = seen_in | hit;
   assign data     = data_ff;
   // Pass the last occupied entry towards the front.
   assign back_out = (count == COUNT_W'(INDEX + 1)) ? data_ff : back_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push_front) begin
         data_in = left_data;
      end else if (ctrl.pop_front) begin
         data_in = right_data;
      end else if (ctrl.push_back && (count == COUNT_W'(INDEX))) begin
         data_in = value;
      end else if (ctrl.del && seen_out) begin
         // close the gap from the first match onwards
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
